// ===== hw/rtl/ubs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubs_pkg
// Shared types and constants of the updater byte scrambler.
// ----------------------------------------------------------------------------
package ubs_pkg;

	localparam int PeriodLen  = 10;
	localparam int GroupLen   = 5;
	localparam int MapOffset  = 7;
	localparam int QueueDepth = 2;

	typedef logic [7:0] byte_t;
	typedef logic [3:0] idx_t;

	typedef struct packed {
		idx_t len;
		logic last;
		logic dir;
	} desc_t;

	typedef struct packed {
		logic  wr;
		idx_t  idx;
		byte_t data;
		logic  commit;
		desc_t desc;
	} front_req_t;

	typedef struct packed {
		idx_t idx;
		logic pop;
	} back_req_t;

	typedef struct packed {
		logic  avail;
		logic  full;
		desc_t desc;
		byte_t data;
	} queue_stat_t;

endpackage

// ===== hw/rtl/updater_byte_scrambler_core.sv =====
`timescale 1ns / 1ps
// Path: the byte that closes a period (tenth byte or end of image) is committed to its
//   queue slot, then the first byte of that period is picked and registered at the output.
// Throughput: one byte per cycle in and out, but for a full queue or out_stall; the period
//   queue holds QueueDepth periods, the one being filled included, before the input stalls.
// Reset clears fill count, queue pointers and count, output position, direction and
//   output valid; period storage is undefined until written.
// ----------------------------------------------------------------------------
// updater_byte_scrambler_core
// Byte image scrambler/descrambler with ten-byte period permutation.
// ----------------------------------------------------------------------------
module updater_byte_scrambler_core #(
	parameter int QueueDepth = ubs_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wen,
	input  logic           cfg_wdata,
	input  logic           in_valid,
	output logic           in_stall,
	input  ubs_pkg::byte_t data_byte,
	input  logic           end_of_image,
	output logic           out_valid,
	input  logic           out_stall,
	output ubs_pkg::byte_t result_byte,
	output logic           result_last
);

	ubs_pkg::front_req_t  freq;
	ubs_pkg::back_req_t   breq;
	ubs_pkg::queue_stat_t stat;

	ubs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.end_of_image (end_of_image),
		.queue_full   (stat.full),
		.req          (freq)
	);

	ubs_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.freq   (freq),
		.breq   (breq),
		.stat   (stat)
	);

	ubs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.stat        (stat),
		.breq        (breq),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_byte (result_byte),
		.result_last (result_last)
	);

endmodule

// ===== hw/rtl/ubs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubs_front
// Accepts bytes, places them into the open period slot and closes the period
// on its tenth byte or on the last byte of the image.
// ----------------------------------------------------------------------------
module ubs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  ubs_pkg::byte_t      data_byte,
	input  logic                end_of_image,
	input  logic                queue_full,
	output ubs_pkg::front_req_t req
);

	ubs_pkg::idx_t fill_q;
	logic          direction_q;
	logic          accept;
	logic          close;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;
	assign close    = end_of_image || (fill_q == ubs_pkg::idx_t'(ubs_pkg::PeriodLen - 1));

	always_comb begin
		req.wr        = accept;
		req.idx       = fill_q;
		req.data      = data_byte;
		req.commit    = accept && close;
		req.desc.len  = fill_q + 4'd1;
		req.desc.last = end_of_image;
		req.desc.dir  = direction_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			direction_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				direction_q <= cfg_wdata;
			end
			if (accept) begin
				// restart the count once the period is handed over
				fill_q <= close ? '0 : fill_q + 4'd1;
			end
		end
	end

endmodule

// ===== hw/rtl/ubs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubs_queue
// Queue of whole periods between front and back: the front fills the tail
// slot, the back drains the head slot.
// ----------------------------------------------------------------------------
module ubs_queue #(
	parameter int Depth = ubs_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ubs_pkg::front_req_t  freq,
	input  ubs_pkg::back_req_t   breq,
	output ubs_pkg::queue_stat_t stat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	ubs_pkg::byte_t mem_q [Depth][ubs_pkg::PeriodLen];
	ubs_pkg::desc_t desc_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign stat.avail = (count_q != '0);
	assign stat.full  = (count_q == CntW'(Depth));
	assign stat.desc  = desc_q[rd_ptr_q];
	assign stat.data  = mem_q[rd_ptr_q][breq.idx];

	always_ff @(posedge clk) begin
		if (freq.wr) begin
			mem_q[wr_ptr_q][freq.idx] <= freq.data;
		end
		if (freq.commit) begin
			desc_q[wr_ptr_q] <= freq.desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (freq.commit) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (breq.pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({freq.commit, breq.pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("period queue overfilled");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		breq.pop |-> count_q != '0)
		else $error("pop from empty period queue");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		freq.wr |-> count_q != CntW'(Depth))
		else $error("byte written into a full period queue");
`endif

endmodule

// ===== hw/rtl/ubs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubs_back
// Walks the head period in output order, picks the permuted source byte,
// applies the nibble map and drives the output register.
// ----------------------------------------------------------------------------
module ubs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ubs_pkg::queue_stat_t stat,
	output ubs_pkg::back_req_t   breq,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ubs_pkg::byte_t       result_byte,
	output logic                 result_last
);

	localparam ubs_pkg::idx_t GrpLast = ubs_pkg::idx_t'(ubs_pkg::GroupLen - 1);
	localparam ubs_pkg::idx_t GrpB    = ubs_pkg::idx_t'(ubs_pkg::GroupLen);
	localparam ubs_pkg::idx_t PerLast = ubs_pkg::idx_t'(ubs_pkg::PeriodLen - 1);
	localparam ubs_pkg::idx_t PerLen  = ubs_pkg::idx_t'(ubs_pkg::PeriodLen);
	localparam logic [3:0]    Offset  = 4'(ubs_pkg::MapOffset);

	function automatic ubs_pkg::idx_t pair_src(input ubs_pkg::idx_t len,
						   input ubs_pkg::idx_t i);
		ubs_pkg::idx_t r;
		r = i;
		if (i[0]) begin
			r = i - 4'd1;
		end else if ((i + 4'd1) < len) begin
			r = i + 4'd1;
		end
		return r;
	endfunction

	function automatic ubs_pkg::idx_t grp_src(input ubs_pkg::idx_t len,
						  input ubs_pkg::idx_t i);
		ubs_pkg::idx_t r;
		r = i;
		priority if (len >= GrpB && i == 4'd0) begin
			r = GrpLast;
		end else if (len >= GrpB && i == GrpLast) begin
			r = 4'd0;
		end else if (len == PerLen && i == GrpB) begin
			r = PerLast;
		end else if (len == PerLen && i == PerLast) begin
			r = GrpB;
		end
		return r;
	endfunction

	function automatic ubs_pkg::byte_t map_byte(input logic dir, input ubs_pkg::byte_t x);
		ubs_pkg::byte_t y;
		if (dir) begin
			y = {x[3:0], x[7:4] + Offset};
		end else begin
			y = {x[3:0] - Offset, x[7:4]};
		end
		return y;
	endfunction

	ubs_pkg::idx_t pos_q;
	logic          out_valid_q;
	logic          issue;
	logic          at_end;
	ubs_pkg::idx_t src;

	assign issue  = stat.avail && (!out_valid_q || !out_stall);
	assign at_end = (pos_q == stat.desc.len - 4'd1);

	always_comb begin
		// decode undoes pairs after groups, encode the reverse
		if (stat.desc.dir) begin
			src = pair_src(stat.desc.len, grp_src(stat.desc.len, pos_q));
		end else begin
			src = grp_src(stat.desc.len, pair_src(stat.desc.len, pos_q));
		end
	end

	assign breq.idx = src;
	assign breq.pop = issue && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				pos_q       <= at_end ? '0 : pos_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			result_byte <= map_byte(stat.desc.dir, stat.data);
			result_last <= stat.desc.last && at_end;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_pos_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		stat.avail |-> pos_q < stat.desc.len)
		else $error("output position beyond period length");
	a_pos_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.avail |-> pos_q == 4'd0)
		else $error("output position left mid-period with queue empty");
	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		stat.avail |-> (stat.desc.len != 4'd0 && stat.desc.len <= PerLen))
		else $error("illegal period length at queue head");
`endif

endmodule
